[sv/ibfp_pkg.sv]
// ----------------------------------------------------------------------------
// ibfp_pkg
// Shared types and constants of the binary frame parser.
// ----------------------------------------------------------------------------
package ibfp_pkg;

  // payload length in bytes and number of 16-bit words per frame
  localparam int PayloadLen = 20;
  localparam int NumWords   = PayloadLen / 2;
  localparam int CountW     = $clog2(PayloadLen);

  // header value after reset
  localparam logic [7:0] SyncReset = 8'h55;

  // one byte request leaving the input register
  typedef struct packed {
    logic       step;
    logic [7:0] data;
  } step_t;

  // payload bytes in arrival order, index 0 first
  typedef logic [PayloadLen-1:0][7:0] payload_t;

  // frame completion towards the result register
  typedef struct packed {
    logic     done;
    payload_t bytes;
  } frame_t;

  typedef logic [NumWords-1:0][15:0] words_t;

endpackage

[sv/imu_binary_frame_parser.sv]
// ----------------------------------------------------------------------------
// imu_binary_frame_parser
// Header-synced fixed-length binary frame parser for a serial sensor stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one received serial byte per request (valid / stall).
//   out_*  : one request per complete frame with ten signed 16-bit raw
//            counts: quaternion z, y, x, w, gyro rate x, y, z, accel x, y, z.
//   cfg_*  : write of the header byte value; cfg_ready is always high.
// A frame is two header bytes followed by 20 payload bytes. A wrong byte in
// the second header slot sends the parser back to hunting.
// Throughput: one byte per cycle while out_stall is not holding a result. A
// byte waits in the input register and is parsed as it leaves; the result for
// the last payload byte then passes through the result register to out_valid.
// When out_stall holds a result, the input register still takes one byte;
// further bytes are stalled until the result is taken.
// Reset (rst_n low, synchronous): hunting for the first header, no result
// pending, header byte value 0x55.
// ----------------------------------------------------------------------------
module imu_binary_frame_parser
  import ibfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_rate_x,
  output logic signed [15:0] out_rate_y,
  output logic signed [15:0] out_rate_z,
  output logic signed [15:0] out_accel_x,
  output logic signed [15:0] out_accel_y,
  output logic signed [15:0] out_accel_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_sync_byte
);

  step_t  step;
  frame_t frame;
  words_t words;
  logic   out_free;

  assign cfg_ready = 1'b1;

  // input register
  ibfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_free   (out_free),
    .step_o     (step)
  );

  // header hunt and payload collection
  ibfp_frame_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_sync_byte (cfg_sync_byte),
    .step_i        (step),
    .frame_o       (frame)
  );

  // result register
  ibfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_i   (frame),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_free  (out_free),
    .words_o   (words)
  );

  assign out_quat_z  = $signed(words[0]);
  assign out_quat_y  = $signed(words[1]);
  assign out_quat_x  = $signed(words[2]);
  assign out_quat_w  = $signed(words[3]);
  assign out_rate_x  = $signed(words[4]);
  assign out_rate_y  = $signed(words[5]);
  assign out_rate_z  = $signed(words[6]);
  assign out_accel_x = $signed(words[7]);
  assign out_accel_y = $signed(words[8]);
  assign out_accel_z = $signed(words[9]);

endmodule

[sv/ibfp_in_reg.sv]
// ----------------------------------------------------------------------------
// ibfp_in_reg
// Input register: holds one byte request until the parser can take it.
// ----------------------------------------------------------------------------
module ibfp_in_reg
  import ibfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_free,
  output step_t      step_o
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       advance;
  logic       accept;

  // held byte moves on whenever the result side has room
  assign advance  = vld_r && out_free;
  assign in_stall = vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_rx_byte;
    end
  end

  assign step_o.step = advance;
  assign step_o.data = data_r;

endmodule

[sv/ibfp_frame_core.sv]
// ----------------------------------------------------------------------------
// ibfp_frame_core
// Header hunt state machine, payload byte counter and payload shift line.
// ----------------------------------------------------------------------------
module ibfp_frame_core
  import ibfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr,
  input  logic [7:0] cfg_sync_byte,
  input  step_t      step_i,
  output frame_t     frame_o
);

  typedef enum logic [1:0] {
    PH_HDR1,
    PH_HDR2,
    PH_DATA
  } phase_t;

  localparam logic [CountW-1:0] LastIdx = CountW'(PayloadLen - 1);

  phase_t            phase_r, phase_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [7:0]        sync_r;
  payload_t          shift_r, shift_nxt;
  logic              is_sync;
  logic              done;

  assign is_sync = (step_i.data == sync_r);

  // next state of the hunt
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    done      = 1'b0;
    if (step_i.step) begin
      case (phase_r)
        PH_HDR2: begin
          count_nxt = '0;
          phase_nxt = is_sync ? PH_DATA : PH_HDR1;
        end
        PH_DATA: begin
          if (count_r == LastIdx) begin
            done      = 1'b1;
            count_nxt = '0;
            phase_nxt = PH_HDR1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        default: begin
          phase_nxt = is_sync ? PH_HDR2 : PH_HDR1;
        end
      endcase
    end
  end

  // payload bytes shift in at the top, oldest ends at index 0
  always_comb begin
    shift_nxt = shift_r;
    if (step_i.step && (phase_r == PH_DATA)) begin
      for (int i = 0; i < PayloadLen - 1; i++) begin
        shift_nxt[i] = shift_r[i+1];
      end
      shift_nxt[PayloadLen-1] = step_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      count_r <= '0;
      sync_r  <= SyncReset;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      if (cfg_wr) begin
        sync_r <= cfg_sync_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  assign frame_o.done  = done;
  assign frame_o.bytes = shift_nxt;

  // byte counter stays inside the payload
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (count_r < CountW'(PayloadLen)))
    else $error("payload byte count out of range");

  // a finished frame always returns to hunting
  a_done_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (phase_r == PH_HDR1) && (count_r == '0))
    else $error("parser did not return to hunt after a frame");

endmodule

[sv/ibfp_out_reg.sv]
// ----------------------------------------------------------------------------
// ibfp_out_reg
// Result register: splits the payload into big-endian words and holds them.
// ----------------------------------------------------------------------------
module ibfp_out_reg
  import ibfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  frame_t frame_i,
  input  logic   out_stall,
  output logic   out_valid,
  output logic   out_free,
  output words_t words_o
);

  logic   vld_r, vld_nxt;
  words_t words_r, words_nxt;

  // room when empty or the held result leaves this cycle
  assign out_free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (frame_i.done) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  // high byte first for each word
  always_comb begin
    for (int k = 0; k < NumWords; k++) begin
      words_nxt[k] = {frame_i.bytes[2*k], frame_i.bytes[2*k+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_i.done) begin
      words_r <= words_nxt;
    end
  end

  assign out_valid = vld_r;
  assign words_o   = words_r;

  // a new frame never lands on a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    frame_i.done |-> out_free)
    else $error("result overwritten while stalled");

endmodule

[tb/imu_binary_frame_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_binary_frame_parser_tb
// Self-checking testbench for the binary frame parser. Serial bytes are sent
// as directed frames and as a random mix of good frames, noise and broken
// headers, under several header values. A local parser model predicts each
// completed frame, and every result request is compared word by word.
// ----------------------------------------------------------------------------
module imu_binary_frame_parser_tb;
  import ibfp_pkg::*;

  typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, READ_PAYLOAD} hunt_state_t;

  localparam int SettleCycles = 4;
  localparam int DrainLimit   = 1000;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte    = 8'h00;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic signed [15:0] out_quat_z;
  logic signed [15:0] out_quat_y;
  logic signed [15:0] out_quat_x;
  logic signed [15:0] out_quat_w;
  logic signed [15:0] out_rate_x;
  logic signed [15:0] out_rate_y;
  logic signed [15:0] out_rate_z;
  logic signed [15:0] out_accel_x;
  logic signed [15:0] out_accel_y;
  logic signed [15:0] out_accel_z;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_sync_byte = 8'h00;

  // parser model state
  hunt_state_t hunt_state    = HUNT_FIRST;
  logic [4:0]  payload_count = '0;
  payload_t    payload_bytes = '0;
  logic [7:0]  sync_value    = SyncReset;

  words_t expected_frames[$];
  int     mismatch_count = 0;
  bit     calm           = 1'b0;

  string word_name [NumWords] = '{"quat_z", "quat_y", "quat_x", "quat_w",
                                  "rate_x", "rate_y", "rate_z",
                                  "accel_x", "accel_y", "accel_z"};

  imu_binary_frame_parser uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_quat_z    (out_quat_z),
    .out_quat_y    (out_quat_y),
    .out_quat_x    (out_quat_x),
    .out_quat_w    (out_quat_w),
    .out_rate_x    (out_rate_x),
    .out_rate_y    (out_rate_y),
    .out_rate_z    (out_rate_z),
    .out_accel_x   (out_accel_x),
    .out_accel_y   (out_accel_y),
    .out_accel_z   (out_accel_z),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_sync_byte (cfg_sync_byte)
  );

  always #5 clk = ~clk;

  // random back-pressure on the result side
  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(0, 99) < 12);
  end

  // model: advance the header hunt by one byte, queue a frame when complete
  function automatic void parse_rx_byte(input logic [7:0] value);
    words_t words;
    case (hunt_state)
      HUNT_SECOND: begin
        if (value == sync_value) begin
          payload_count = '0;
          hunt_state = READ_PAYLOAD;
        end else begin
          hunt_state = HUNT_FIRST;
        end
      end
      READ_PAYLOAD: begin
        if (payload_count < PayloadLen) payload_bytes[payload_count] = value;
        payload_count = payload_count + 5'd1;
        if (payload_count >= PayloadLen) begin
          for (int k = 0; k < NumWords; k++) begin
            words[k] = {payload_bytes[2*k], payload_bytes[2*k+1]};
          end
          expected_frames.push_back(words);
          hunt_state = HUNT_FIRST;
        end
      end
      default: begin
        hunt_state = (value == sync_value) ? HUNT_SECOND : HUNT_FIRST;
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    words_t got;
    words_t want;
    if (rst_n && out_valid && !out_stall) begin
      got[0] = out_quat_z;
      got[1] = out_quat_y;
      got[2] = out_quat_x;
      got[3] = out_quat_w;
      got[4] = out_rate_x;
      got[5] = out_rate_y;
      got[6] = out_rate_z;
      got[7] = out_accel_x;
      got[8] = out_accel_y;
      got[9] = out_accel_z;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected frame request, expected none, got quat_z %0d",
                 $time, $signed(got[0]));
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        for (int k = 0; k < NumWords; k++) begin
          if (got[k] !== want[k]) begin
            $display("%0t: %s expected %0d got %0d", $time, word_name[k],
                     $signed(want[k]), $signed(got[k]));
            mismatch_count++;
          end
        end
      end
    end
  end

  // send one byte request; called and returning at a falling edge
  task automatic send_byte(input logic [7:0] value);
    while (!calm && ($urandom_range(0, 99) < 12)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    do @(posedge clk); while (in_stall);
    parse_rx_byte(value);
    @(negedge clk);
  endtask

  // header bytes followed by the payload
  task automatic send_frame(input payload_t payload);
    send_byte(sync_value);
    send_byte(sync_value);
    for (int i = 0; i < PayloadLen; i++) send_byte(payload[i]);
  endtask

  // byte mix weighted toward the header value and sign boundaries
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return sync_value;
      1: return 8'h00;
      2: return 8'hFF;
      3: return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_non_sync();
    logic [7:0] value;
    do value = 8'($urandom_range(0, 255)); while (value == sync_value);
    return value;
  endfunction

  function automatic payload_t random_payload();
    payload_t payload;
    for (int i = 0; i < PayloadLen; i++) payload[i] = pick_byte();
    return payload;
  endfunction

  // let the parser go idle, then write the header value
  task automatic write_sync(input logic [7:0] value);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_sync_byte <= value;
    do @(posedge clk); while (!cfg_ready);
    sync_value = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // default header value: broken second slot, then a frame with extreme words
  task automatic test_directed_bytes();
    logic [7:0] stream [25] = '{8'hFF, 8'h55, 8'hA0, 8'h55, 8'h55,
                                8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF,
                                8'hFF, 8'h00, 8'h00, 8'h55, 8'h55,
                                8'h00, 8'h01, 8'hFF, 8'h80, 8'h00,
                                8'h55, 8'h55, 8'hAA, 8'h12, 8'h34};
    for (int i = 0; i < 25; i++) send_byte(stream[i]);
  endtask

  // header value at its extremes; the old value must no longer sync
  task automatic test_sync_extremes();
    write_sync(8'h00);
    send_byte(8'h55);
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'h01);
    send_frame(random_payload());
    write_sync(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_frame(random_payload());
    send_byte(8'hFF);
    send_byte(8'hFE);
    send_frame(random_payload());
  endtask

  // mostly good frames with random content, plus noise and broken headers
  task automatic test_random_stream();
    int sent;
    int r;
    for (int seg = 0; seg < 4; seg++) begin
      write_sync(8'($urandom_range(0, 255)));
      calm = (seg == 1);
      sent = 0;
      while (sent < 300) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_frame(random_payload());
          sent += PayloadLen + 2;
        end else if (r < 82) begin
          repeat ($urandom_range(1, 3)) begin
            send_byte(pick_byte());
            sent++;
          end
        end else if (r < 94) begin
          send_byte(sync_value);
          send_byte(pick_non_sync());
          sent += 2;
        end else begin
          // truncated frame: the next header lands in the payload
          send_byte(sync_value);
          send_byte(sync_value);
          repeat ($urandom_range(1, PayloadLen - 1)) begin
            send_byte(pick_byte());
            sent++;
          end
          sent += 2;
        end
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_bytes();
    test_sync_extremes();
    test_random_stream();
    in_valid <= 1'b0;
    waited = 0;
    while (expected_frames.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_frames.size() != 0) begin
      $display("%0t: %0d frame requests expected but never seen", $time,
               expected_frames.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
